// ===== src/lpbp_pkg.sv =====
// ----------------------------------------------------------------------------
// lpbp_pkg
// Shared types and constants of the LRU page buffer pool frame table.
// ----------------------------------------------------------------------------
package lpbp_pkg;

    localparam int FRAMES_DEF       = 16;
    localparam int FILE_ID_BITS_DEF = 8;

    localparam int KIND_W      = 2;
    localparam int FILE_W      = 8;
    localparam int PAGE_W      = 32;
    localparam int STAMP_W     = 32;
    localparam int STATUS_W    = 3;
    localparam int FRAME_OUT_W = 4;

    typedef enum logic [KIND_W-1:0] {
        KIND_REQUEST = 2'd0,
        KIND_DIRTY   = 2'd1,
        KIND_RELEASE = 2'd2,
        KIND_DROP    = 2'd3
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_HIT     = 3'd0,
        STAT_LOADED  = 3'd1,
        STAT_ABSENT  = 3'd2,
        STAT_TAIL    = 3'd3,
        STAT_NOFRAME = 3'd4,
        STAT_NOTPIN  = 3'd5,
        STAT_DONE    = 3'd6
    } status_t;

    typedef struct packed {
        kind_t             kind;
        logic [FILE_W-1:0] file_id;
        logic [PAGE_W-1:0] page_number;
        logic [PAGE_W-1:0] file_pages;
        logic              allocate;
    } req_t;

    typedef struct packed {
        status_t                status;
        logic [FRAME_OUT_W-1:0] frame;
        logic                   writeback;
        logic [FILE_W-1:0]      victim_file;
        logic [PAGE_W-1:0]      victim_page;
    } rsp_t;

endpackage

// ===== src/lpbp_chan_if.sv =====
// ----------------------------------------------------------------------------
// lpbp_chan_if
// Valid/ready channel carrying one request or response payload.
// ----------------------------------------------------------------------------
interface lpbp_chan_if #(
    parameter type data_t = logic
);
    logic  valid;
    logic  ready;
    data_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== src/lru_page_buffer_pool_core.sv =====
// ----------------------------------------------------------------------------
// lru_page_buffer_pool_core
// Frame table of an LRU page buffer pool: lookup, tail check, victim pick, dirty, release, drop.
// ----------------------------------------------------------------------------
// Usage:
//   req (sink) carries one request: kind, file_id, page_number, file_pages,
//   allocate. rsp (source) carries exactly one response per request: status,
//   frame, writeback, victim_file, victim_page. Both use valid/ready.
//   Each request walks the frame memory one frame per cycle, comparing tags,
//   tracking the first clean unpinned frame and the least-stamped unpinned
//   frame. From acceptance, a request reads each frame in turn, evaluates
//   the registered data of each read, then decides and waits for the output
//   register to be free; the frame memory's single read port makes the walk
//   serial. req.ready is high only while idle, so the next request can be
//   accepted the cycle after the response is loaded, and the block takes no
//   new request before it is through with the last one.
//   The response sits in an output register; a new request may be accepted
//   while it waits, and the block holds its result until rsp is free.
//   Reset clears the occupied, pinned and dirty flags, the stamp counter and
//   the output; free frames' tags and stamps are read but never decide.
// ----------------------------------------------------------------------------
module lru_page_buffer_pool_core #(
    parameter int FRAMES       = lpbp_pkg::FRAMES_DEF,
    parameter int FILE_ID_BITS = lpbp_pkg::FILE_ID_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    lpbp_chan_if.sink          req,
    lpbp_chan_if.source        rsp
);
    import lpbp_pkg::*;

    localparam int FRAME_BITS = $clog2(FRAMES);
    localparam logic [FRAME_BITS-1:0] LAST_FRAME = FRAME_BITS'(FRAMES - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE
    } state_t;

    // Frame memory: tags and use stamps, one read and one write port
    logic [FILE_ID_BITS-1:0] tag_file_mem [FRAMES];
    logic [PAGE_W-1:0]       tag_page_mem [FRAMES];
    logic [STAMP_W-1:0]      stamp_mem    [FRAMES];

    logic [FILE_ID_BITS-1:0] rd_file_reg;
    logic [PAGE_W-1:0]       rd_page_reg;
    logic [STAMP_W-1:0]      rd_stamp_reg;

    logic                    mem_we;
    logic [FRAME_BITS-1:0]   mem_addr;
    logic [FILE_ID_BITS-1:0] mem_file;
    logic [PAGE_W-1:0]       mem_page;
    logic [STAMP_W-1:0]      mem_stamp;

    state_t                  state_reg, state_next;
    kind_t                   kind_reg, kind_next;
    logic [FILE_ID_BITS-1:0] fid_reg, fid_next;
    logic [PAGE_W-1:0]       page_reg, page_next;
    logic [PAGE_W-1:0]       tail_reg, tail_next;
    logic                    alloc_reg, alloc_next;

    logic [FRAMES-1:0]       occupied_reg, occupied_next;
    logic [FRAMES-1:0]       pinned_reg, pinned_next;
    logic [FRAMES-1:0]       dirty_reg, dirty_next;
    logic [STAMP_W-1:0]      stamp_cnt_reg, stamp_cnt_next;

    logic [FRAME_BITS-1:0]   addr_reg, addr_next;
    logic                    issue_done_reg, issue_done_next;
    logic                    rvalid_reg, rvalid_next;
    logic [FRAME_BITS-1:0]   ridx_reg, ridx_next;

    logic                    hit_found_reg, hit_found_next;
    logic [FRAME_BITS-1:0]   hit_idx_reg, hit_idx_next;
    logic                    clean_found_reg, clean_found_next;
    logic [FRAME_BITS-1:0]   clean_idx_reg, clean_idx_next;
    logic                    lru_found_reg, lru_found_next;
    logic [FRAME_BITS-1:0]   lru_idx_reg, lru_idx_next;
    logic [STAMP_W-1:0]      lru_stamp_reg, lru_stamp_next;
    logic [FILE_ID_BITS-1:0] lru_file_reg, lru_file_next;
    logic [PAGE_W-1:0]       lru_page_reg, lru_page_next;
    logic                    lru_dirty_reg, lru_dirty_next;

    logic                    out_valid_reg, out_valid_next;
    status_t                 out_status_reg, out_status_next;
    logic [FRAME_OUT_W-1:0]  out_frame_reg, out_frame_next;
    logic                    out_wb_reg, out_wb_next;
    logic [FILE_W-1:0]       out_vfile_reg, out_vfile_next;
    logic [PAGE_W-1:0]       out_vpage_reg, out_vpage_next;

    logic                    cur_occ, cur_pin, cur_dirty, cur_match;
    logic                    out_free;
    logic [STAMP_W-1:0]      stamp_inc;
    logic [FRAME_BITS-1:0]   pick_idx;

    assign req.ready = (state_reg == S_IDLE);

    assign rsp.valid            = out_valid_reg;
    assign rsp.data.status      = out_status_reg;
    assign rsp.data.frame       = out_frame_reg;
    assign rsp.data.writeback   = out_wb_reg;
    assign rsp.data.victim_file = out_vfile_reg;
    assign rsp.data.victim_page = out_vpage_reg;

    assign out_free  = !out_valid_reg || rsp.ready;
    assign stamp_inc = (stamp_cnt_reg == '1) ? stamp_cnt_reg : stamp_cnt_reg + STAMP_W'(1);
    assign pick_idx  = clean_found_reg ? clean_idx_reg : lru_idx_reg;

    assign cur_occ   = occupied_reg[ridx_reg];
    assign cur_pin   = pinned_reg[ridx_reg];
    assign cur_dirty = dirty_reg[ridx_reg];
    assign cur_match = cur_occ && (rd_file_reg == fid_reg) && (rd_page_reg == page_reg);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            tag_file_mem[mem_addr] <= mem_file;
            tag_page_mem[mem_addr] <= mem_page;
            stamp_mem[mem_addr]    <= mem_stamp;
        end
        rd_file_reg  <= tag_file_mem[addr_reg];
        rd_page_reg  <= tag_page_mem[addr_reg];
        rd_stamp_reg <= stamp_mem[addr_reg];
    end

    always_comb
    begin
        state_next       = state_reg;
        kind_next        = kind_reg;
        fid_next         = fid_reg;
        page_next        = page_reg;
        tail_next        = tail_reg;
        alloc_next       = alloc_reg;
        occupied_next    = occupied_reg;
        pinned_next      = pinned_reg;
        dirty_next       = dirty_reg;
        stamp_cnt_next   = stamp_cnt_reg;
        addr_next        = addr_reg;
        issue_done_next  = issue_done_reg;
        rvalid_next      = 1'b0;
        ridx_next        = addr_reg;
        hit_found_next   = hit_found_reg;
        hit_idx_next     = hit_idx_reg;
        clean_found_next = clean_found_reg;
        clean_idx_next   = clean_idx_reg;
        lru_found_next   = lru_found_reg;
        lru_idx_next     = lru_idx_reg;
        lru_stamp_next   = lru_stamp_reg;
        lru_file_next    = lru_file_reg;
        lru_page_next    = lru_page_reg;
        lru_dirty_next   = lru_dirty_reg;
        out_valid_next   = out_valid_reg && !rsp.ready;
        out_status_next  = out_status_reg;
        out_frame_next   = out_frame_reg;
        out_wb_next      = out_wb_reg;
        out_vfile_next   = out_vfile_reg;
        out_vpage_next   = out_vpage_reg;
        mem_we           = 1'b0;
        mem_addr         = pick_idx;
        mem_file         = fid_reg;
        mem_page         = page_reg;
        mem_stamp        = stamp_inc;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    kind_next        = req.data.kind;
                    fid_next         = FILE_ID_BITS'(req.data.file_id);
                    page_next        = req.data.page_number;
                    tail_next        = req.data.file_pages;
                    alloc_next       = req.data.allocate;
                    addr_next        = '0;
                    issue_done_next  = 1'b0;
                    hit_found_next   = 1'b0;
                    clean_found_next = 1'b0;
                    lru_found_next   = 1'b0;
                    state_next       = S_SCAN;
                end
            end

            S_SCAN:
            begin
                // Issue one frame read per cycle; evaluate it the cycle after
                if (!issue_done_reg)
                begin
                    rvalid_next = 1'b1;
                    if (addr_reg == LAST_FRAME)
                        issue_done_next = 1'b1;
                    else
                        addr_next = addr_reg + FRAME_BITS'(1);
                end
                if (rvalid_reg)
                begin
                    if (cur_match && !hit_found_reg)
                    begin
                        hit_found_next = 1'b1;
                        hit_idx_next   = ridx_reg;
                    end
                    if (!cur_pin && !cur_dirty && !clean_found_reg)
                    begin
                        clean_found_next = 1'b1;
                        clean_idx_next   = ridx_reg;
                    end
                    // Strict compare keeps the lowest index on equal stamps
                    if (!cur_pin && (!lru_found_reg || rd_stamp_reg < lru_stamp_reg))
                    begin
                        lru_found_next = 1'b1;
                        lru_idx_next   = ridx_reg;
                        lru_stamp_next = rd_stamp_reg;
                        lru_file_next  = rd_file_reg;
                        lru_page_next  = rd_page_reg;
                        lru_dirty_next = cur_occ && cur_dirty;
                    end
                    if (kind_reg == KIND_DROP && cur_occ && rd_file_reg == fid_reg)
                    begin
                        occupied_next[ridx_reg] = 1'b0;
                        pinned_next[ridx_reg]   = 1'b0;
                        dirty_next[ridx_reg]    = 1'b0;
                    end
                    if (ridx_reg == LAST_FRAME)
                        state_next = S_DECIDE;
                end
            end

            S_DECIDE:
            begin
                // Hold the result until the output register is free
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = STAT_DONE;
                    out_frame_next  = '0;
                    out_wb_next     = 1'b0;
                    out_vfile_next  = '0;
                    out_vpage_next  = '0;
                    state_next      = S_IDLE;
                    case (kind_reg) inside
                        KIND_REQUEST:
                        begin
                            if (hit_found_reg)
                            begin
                                pinned_next[hit_idx_reg] = 1'b1;
                                stamp_cnt_next           = stamp_inc;
                                mem_we                   = 1'b1;
                                mem_addr                 = hit_idx_reg;
                                out_status_next          = STAT_HIT;
                                out_frame_next           = FRAME_OUT_W'(hit_idx_reg);
                            end
                            else if (page_reg >= tail_reg && !alloc_reg)
                                out_status_next = STAT_ABSENT;
                            else if (page_reg > tail_reg)
                                out_status_next = STAT_TAIL;
                            else if (!clean_found_reg && !lru_found_reg)
                                out_status_next = STAT_NOFRAME;
                            else
                            begin
                                occupied_next[pick_idx] = 1'b1;
                                pinned_next[pick_idx]   = 1'b1;
                                dirty_next[pick_idx]    = 1'b0;
                                stamp_cnt_next          = stamp_inc;
                                mem_we                  = 1'b1;
                                out_status_next         = STAT_LOADED;
                                out_frame_next          = FRAME_OUT_W'(pick_idx);
                                if (!clean_found_reg && lru_dirty_reg)
                                begin
                                    out_wb_next    = 1'b1;
                                    out_vfile_next = FILE_W'(lru_file_reg);
                                    out_vpage_next = lru_page_reg;
                                end
                            end
                        end
                        KIND_DIRTY,
                        KIND_RELEASE:
                        begin
                            if (!hit_found_reg)
                                out_status_next = STAT_ABSENT;
                            else if (!pinned_reg[hit_idx_reg])
                            begin
                                out_status_next = STAT_NOTPIN;
                                out_frame_next  = FRAME_OUT_W'(hit_idx_reg);
                            end
                            else
                            begin
                                if (kind_reg == KIND_DIRTY)
                                    dirty_next[hit_idx_reg] = 1'b1;
                                else
                                    pinned_next[hit_idx_reg] = 1'b0;
                                out_frame_next = FRAME_OUT_W'(hit_idx_reg);
                            end
                        end
                        default:
                        begin
                            // Drop already cleared its frames during the walk
                            out_status_next = STAT_DONE;
                        end
                    endcase
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            occupied_reg    <= '0;
            pinned_reg      <= '0;
            dirty_reg       <= '0;
            stamp_cnt_reg   <= '0;
            issue_done_reg  <= 1'b0;
            rvalid_reg      <= 1'b0;
            hit_found_reg   <= 1'b0;
            clean_found_reg <= 1'b0;
            lru_found_reg   <= 1'b0;
            out_valid_reg   <= 1'b0;
            addr_reg        <= '0;
            kind_reg        <= KIND_REQUEST;
            fid_reg         <= '0;
            page_reg        <= '0;
            tail_reg        <= '0;
            alloc_reg       <= 1'b0;
            ridx_reg        <= '0;
            hit_idx_reg     <= '0;
            clean_idx_reg   <= '0;
            lru_idx_reg     <= '0;
            lru_stamp_reg   <= '0;
            lru_file_reg    <= '0;
            lru_page_reg    <= '0;
            lru_dirty_reg   <= 1'b0;
            out_status_reg  <= STAT_HIT;
            out_frame_reg   <= '0;
            out_wb_reg      <= 1'b0;
            out_vfile_reg   <= '0;
            out_vpage_reg   <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            occupied_reg    <= occupied_next;
            pinned_reg      <= pinned_next;
            dirty_reg       <= dirty_next;
            stamp_cnt_reg   <= stamp_cnt_next;
            issue_done_reg  <= issue_done_next;
            rvalid_reg      <= rvalid_next;
            hit_found_reg   <= hit_found_next;
            clean_found_reg <= clean_found_next;
            lru_found_reg   <= lru_found_next;
            out_valid_reg   <= out_valid_next;
            addr_reg        <= addr_next;
            kind_reg        <= kind_next;
            fid_reg         <= fid_next;
            page_reg        <= page_next;
            tail_reg        <= tail_next;
            alloc_reg       <= alloc_next;
            ridx_reg        <= ridx_next;
            hit_idx_reg     <= hit_idx_next;
            clean_idx_reg   <= clean_idx_next;
            lru_idx_reg     <= lru_idx_next;
            lru_stamp_reg   <= lru_stamp_next;
            lru_file_reg    <= lru_file_next;
            lru_page_reg    <= lru_page_next;
            lru_dirty_reg   <= lru_dirty_next;
            out_status_reg  <= out_status_next;
            out_frame_reg   <= out_frame_next;
            out_wb_reg      <= out_wb_next;
            out_vfile_reg   <= out_vfile_next;
            out_vpage_reg   <= out_vpage_next;
        end
    end

endmodule

// ===== src/lpbp_checker.sv =====
// ----------------------------------------------------------------------------
// lpbp_checker
// Port-level checks of the page buffer pool frame table, bound to the core.
// ----------------------------------------------------------------------------
module lpbp_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          req_valid,
    input logic          req_ready,
    input logic          rsp_valid,
    input logic          rsp_ready,
    input lpbp_pkg::rsp_t rsp_data
);
    import lpbp_pkg::*;

    // A stalled response holds its payload
    ap_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
        else $error("response changed while stalled");

    // One request at a time: busy right after acceptance
    ap_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request accepted while busy");

    // Writeback only comes with a load
    ap_wb_load: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_data.writeback |-> rsp_data.status == STAT_LOADED)
        else $error("writeback without load");

    // Refused requests name no frame and no victim
    ap_refused: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_data.status == STAT_ABSENT || rsp_data.status == STAT_TAIL ||
                      rsp_data.status == STAT_NOFRAME)
        |-> rsp_data.frame == '0 && !rsp_data.writeback)
        else $error("refused request carries a frame");

    // Victim fields are zero unless a writeback is due
    ap_victim_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_data.writeback
        |-> rsp_data.victim_file == '0 && rsp_data.victim_page == '0)
        else $error("victim fields set without writeback");

endmodule

bind lru_page_buffer_pool_core lpbp_checker u_lpbp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .rsp_data  (rsp.data)
);
